[rtl/stid_pkg.sv]
// ----------------------------------------------------------------------------
// stid_pkg : shared types and constants for the sorted table core
// Operation and status codes, table geometry, sequencer states, divider port types.
// ----------------------------------------------------------------------------
`default_nettype none
package stid_pkg;
    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 38;
    localparam int MEAN_W  = 40;
    localparam int DIV_W   = SUM_W + 8;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SHIFT_UP, S_WRITE, S_SHIFT_DN,
        S_RDLO, S_RDHI, S_DIV, S_DUMP_RD, S_EMIT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic signed [MEAN_W-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

[rtl/stid_divider.sv]
// ----------------------------------------------------------------------------
// stid_divider : restoring divider for the mean
// One quotient bit a cycle, sum*256 / count truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module stid_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire stid_pkg::div_req_t req,
    output stid_pkg::div_rsp_t  rsp
);
    localparam int DW = stid_pkg::DIV_W;
    localparam int CW = stid_pkg::CNT_W;

    logic [DW-1:0]      quo_reg, quo_next;
    logic [CW:0]        rem_reg, rem_next;
    logic [CW-1:0]      dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [CW:0]        trial;
    logic [DW-1:0]      mag;
    logic [DW-1:0]      qs;

    always_comb
    begin
        mag = {req.dividend[stid_pkg::SUM_W-1] ? -req.dividend : req.dividend, 8'd0};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[CW-1:0], quo_reg[DW-1]};
        if (req.start)
        begin
            quo_next  = mag;
            rem_next  = '0;
            dvs_next  = req.divisor;
            neg_next  = req.dividend[stid_pkg::SUM_W-1];
            cnt_next  = 6'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign qs  = neg_reg ? -quo_reg : quo_reg;
    assign rsp = {busy_reg, qs[stid_pkg::MEAN_W-1:0]};
endmodule
`default_nettype wire

[rtl/sorted_table_insert_delete_core.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_core : sorted value table with statistics
// Insert, delete and dump over an ascending table, with count, sum, min,
// max and mean carried on every result.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata = func[1:0], value[33:2]
// m_axis   out  tdata = status, element, entry_count, total, smallest,
//                       largest, mean_fixed ; tlast = last
//
// One request: a search over the held entries, a read and a write for
// each entry moved on insert or delete, one write, a read each for min and
// max, then the divider for the mean. A dump then emits one result per
// held entry, each read from the table in turn.
// Reset clears count and sum; unwritten entries never reach a result.
// A stalled result holds; no new request is taken until the last is taken.
`default_nettype none
module sorted_table_insert_delete_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,   // func[1:0], value[33:2], zero pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [183:0]      m_axis_tdata,   // status, element, entry_count,
                                              // total, smallest, largest,
                                              // mean_fixed, zero pad
    output logic              m_axis_tlast
);
    localparam int IW = stid_pkg::IDX_W;
    localparam int CW = stid_pkg::CNT_W;
    localparam int SW = stid_pkg::SUM_W;

    // table memory, one write port and one read port, registered read
    logic signed [31:0] mem [stid_pkg::DEPTH];
    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic signed [31:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    stid_pkg::state_t state_reg, state_next;
    logic [1:0]         func_reg, func_next;
    logic signed [31:0] val_reg, val_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0]      idx_reg, idx_next;     // search/shift pointer
    logic               rdv_reg, rdv_next;     // read data valid for idx-1
    logic [1:0]         stat_reg, stat_next;
    logic signed [31:0] elem_reg, elem_next;
    logic signed [31:0] lo_reg, lo_next, hi_reg, hi_next;
    logic               last_reg, last_next;
    logic               ov_reg, ov_next;
    stid_pkg::div_req_t dreq;
    stid_pkg::div_rsp_t drsp;

    stid_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic acc_in;
    assign s_axis_tready = (state_reg == stid_pkg::S_IDLE);
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg; val_next = val_reg; cnt_next = cnt_reg;
        sum_next = sum_reg; idx_next = idx_reg; rdv_next = 1'b0;
        stat_next = stat_reg; elem_next = elem_reg; lo_next = lo_reg;
        hi_next = hi_reg; last_next = last_reg; ov_next = ov_reg;
        we = 1'b0; waddr = idx_reg[IW-1:0]; wdata = val_reg;
        raddr = idx_reg[IW-1:0];
        dreq.start = 1'b0; dreq.dividend = sum_reg; dreq.divisor = cnt_reg;
        case (state_reg)
            stid_pkg::S_IDLE:
            begin
                if (acc_in)
                begin
                    func_next = s_axis_tdata[1:0];
                    val_next  = s_axis_tdata[33:2];
                    idx_next  = '0;
                    stat_next = stid_pkg::ST_OK;
                    elem_next = '0;
                    last_next = 1'b1;
                    case (s_axis_tdata[1:0])
                        stid_pkg::FUNC_INSERT:
                        begin
                            if (cnt_reg >= CW'(stid_pkg::DEPTH))
                            begin
                                stat_next  = stid_pkg::ST_FULL;
                                state_next = stid_pkg::S_RDLO;
                            end
                            else
                                state_next = stid_pkg::S_SEARCH;
                        end
                        stid_pkg::FUNC_DELETE: state_next = stid_pkg::S_SEARCH;
                        stid_pkg::FUNC_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = stid_pkg::ST_EMPTY;
                                state_next = stid_pkg::S_EMIT;
                            end
                            else
                                state_next = stid_pkg::S_RDLO;
                        end
                        default: state_next = stid_pkg::S_RDLO;
                    endcase
                end
            end
            stid_pkg::S_SEARCH:
            begin
                // read idx; compare previous read (idx-1)
                rdv_next = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (rdv_reg && (func_reg == stid_pkg::FUNC_INSERT
                        ? (rdata_reg >= val_reg) : (rdata_reg == val_reg)))
                begin
                    idx_next = idx_reg - 1'b1;   // hit position
                    rdv_next = 1'b0;
                    if (func_reg == stid_pkg::FUNC_INSERT)
                    begin
                        idx_next   = cnt_reg;
                        state_next = stid_pkg::S_SHIFT_UP;
                        ov_next    = 1'b0;
                        elem_next  = 32'(idx_reg - 1'b1); // stop index
                    end
                    else
                        state_next = stid_pkg::S_SHIFT_DN;
                end
                else if (idx_reg == cnt_reg)
                begin
                    rdv_next = 1'b0;
                    if (func_reg == stid_pkg::FUNC_INSERT)
                    begin
                        idx_next   = cnt_reg;
                        state_next = stid_pkg::S_WRITE;
                    end
                    else
                    begin
                        stat_next  = stid_pkg::ST_NOTFOUND;
                        state_next = stid_pkg::S_RDLO;
                    end
                end
            end
            stid_pkg::S_SHIFT_UP:
            begin
                // move [idx-1] to [idx] down to the stop index
                if (idx_reg[CW-1:0] == elem_reg[CW-1:0])
                begin
                    state_next = stid_pkg::S_WRITE;
                    elem_next  = '0;
                end
                else if (!ov_reg)
                begin
                    raddr   = IW'(idx_reg - 1'b1);
                    ov_next = 1'b1;
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = rdata_reg;
                    ov_next  = 1'b0;
                    idx_next = idx_reg - 1'b1;
                end
            end
            stid_pkg::S_WRITE:
            begin
                we        = 1'b1;
                elem_next = '0;
                cnt_next  = cnt_reg + 1'b1;
                sum_next  = sum_reg + SW'(val_reg);
                state_next = stid_pkg::S_RDLO;
            end
            stid_pkg::S_SHIFT_DN:
            begin
                // move [idx+1] to [idx] up to count-1
                if (CW'(idx_reg + 1'b1) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    sum_next   = sum_reg - SW'(val_reg);
                    state_next = stid_pkg::S_RDLO;
                end
                else if (!ov_reg)
                begin
                    raddr   = IW'(idx_reg + 1'b1);
                    ov_next = 1'b1;
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = rdata_reg;
                    ov_next  = 1'b0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            stid_pkg::S_RDLO:
            begin
                ov_next = 1'b0;
                raddr   = '0;
                state_next = stid_pkg::S_RDHI;
            end
            stid_pkg::S_RDHI:
            begin
                lo_next = rdata_reg;
                raddr   = IW'(cnt_reg - 1'b1);
                dreq.start = (cnt_reg != '0);
                state_next = stid_pkg::S_DIV;
            end
            stid_pkg::S_DIV:
            begin
                if (!ov_reg)
                begin
                    hi_next = rdata_reg;
                    ov_next = 1'b1;
                end
                if (!drsp.busy && ov_reg)
                begin
                    ov_next = 1'b0;
                    if (func_reg == stid_pkg::FUNC_DUMP)
                    begin
                        idx_next   = '0;
                        state_next = stid_pkg::S_DUMP_RD;
                    end
                    else
                        state_next = stid_pkg::S_EMIT;
                end
            end
            stid_pkg::S_DUMP_RD:
            begin
                // address, then capture of the registered read
                raddr = idx_reg[IW-1:0];
                if (ov_reg)
                begin
                    elem_next  = rdata_reg;
                    last_next  = (CW'(idx_reg + 1'b1) == cnt_reg);
                    ov_next    = 1'b0;
                    state_next = stid_pkg::S_EMIT;
                end
                else
                    ov_next = 1'b1;
            end
            stid_pkg::S_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if (func_reg == stid_pkg::FUNC_DUMP && !last_reg)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = stid_pkg::S_DUMP_RD;
                    end
                    else
                        state_next = stid_pkg::S_IDLE;
                end
            end
            default: state_next = stid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stid_pkg::S_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            rdv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            rdv_reg   <= rdv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next; val_reg <= val_next; idx_reg <= idx_next;
        stat_reg <= stat_next; elem_reg <= elem_next; lo_reg <= lo_next;
        hi_reg <= hi_next; last_reg <= last_next;
    end

    // result view; statistics read zero on an empty table
    logic empty;
    assign empty = (cnt_reg == '0);
    assign m_axis_tvalid = (state_reg == stid_pkg::S_EMIT);
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {
        1'b0,
        empty ? 40'sd0 : drsp.quotient,
        empty ? 32'sd0 : hi_reg,
        empty ? 32'sd0 : lo_reg,
        empty ? 38'sd0 : sum_reg,
        cnt_reg,
        elem_reg,
        stat_reg
    };
endmodule
`default_nettype wire

[rtl/stid_checker.sv]
// ----------------------------------------------------------------------------
// stid_checker : port-level checks for the sorted table core
// Handshake and result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none
module stid_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [183:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // a waiting request stays offered
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
        else $error("request withdrawn before taken");
    // no request taken while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("ready while result pending");
    // empty status comes with zero count and last set
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == stid_pkg::ST_EMPTY
            |-> m_axis_tdata[40:34] == 7'd0 && m_axis_tlast)
        else $error("empty status with entries");
    // count never exceeds table size
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:34] <= 7'(stid_pkg::DEPTH))
        else $error("count beyond depth");
endmodule

bind sorted_table_insert_delete_core stid_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

[bench/tb_sorted_table_insert_delete_core.sv]
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_delete_core : self-checking bench for the sorted table
// Drives insert, delete, dump and the spare code on the request stream, keeps
// its own sorted copy of the table and checks every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [6:0]         entry_count;
    logic signed [37:0] total;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic signed [39:0] mean_fixed;
} table_result_t;

// Holds the table image and the queue of results still owed by the block.
class table_scoreboard;
    longint        held[$];          // ascending copy of the table
    longint        sum_now;
    table_result_t owed[$];
    int            errors;
    int            results_seen;

    function void push_result(logic [1:0] st, longint elem, bit lst);
        table_result_t r;
        longint        mean;
        longint        lo;
        longint        hi;
        mean = 0;
        lo   = 0;
        hi   = 0;
        if (held.size() > 0)
        begin
            mean = (sum_now * 256) / longint'(held.size());
            lo   = held[0];
            hi   = held[held.size()-1];
        end
        r.status      = st;
        r.element     = elem[31:0];
        r.last        = lst;
        r.entry_count = 7'(held.size());
        r.total       = (held.size() > 0) ? sum_now[37:0] : '0;
        r.smallest    = lo[31:0];
        r.largest     = hi[31:0];
        r.mean_fixed  = mean[39:0];
        owed.push_back(r);
    endfunction

    // called for each accepted request
    function void note_request(logic [1:0] op, logic signed [31:0] val);
        int     idx;
        longint v;
        v = val;
        case (op)
            stid_pkg::FUNC_INSERT:
            begin
                if (held.size() >= stid_pkg::DEPTH)
                    push_result(stid_pkg::ST_FULL, 0, 1);
                else
                begin
                    idx = 0;
                    while (idx < held.size() && held[idx] < v)
                        idx++;
                    held.insert(idx, v);
                    sum_now += v;
                    push_result(stid_pkg::ST_OK, 0, 1);
                end
            end
            stid_pkg::FUNC_DELETE:
            begin
                idx = 0;
                while (idx < held.size() && held[idx] != v)
                    idx++;
                if (idx >= held.size())
                    push_result(stid_pkg::ST_NOTFOUND, 0, 1);
                else
                begin
                    held.delete(idx);
                    sum_now -= v;
                    push_result(stid_pkg::ST_OK, 0, 1);
                end
            end
            stid_pkg::FUNC_DUMP:
            begin
                if (held.size() == 0)
                    push_result(stid_pkg::ST_EMPTY, 0, 1);
                else
                    for (int k = 0; k < held.size(); k++)
                        push_result(stid_pkg::ST_OK, held[k], k == held.size() - 1);
            end
            default:
                push_result(stid_pkg::ST_OK, 0, 1);   // spare code: statistics only
        endcase
    endfunction

    function void check_result(logic [183:0] d, logic lst);
        table_result_t e;
        results_seen++;
        if (owed.size() == 0)
        begin
            $error("unexpected result beat, data %h", d);
            errors++;
            return;
        end
        e = owed.pop_front();
        if (d[1:0] !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, d[1:0]);
            errors++;
        end
        if (d[33:2] !== e.element)
        begin
            $error("element: expected %0d, got %0d", e.element, $signed(d[33:2]));
            errors++;
        end
        if (lst !== e.last)
        begin
            $error("last: expected %0d, got %0d", e.last, lst);
            errors++;
        end
        if (d[40:34] !== e.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, d[40:34]);
            errors++;
        end
        if (d[78:41] !== e.total)
        begin
            $error("total: expected %0d, got %0d", e.total, $signed(d[78:41]));
            errors++;
        end
        if (d[110:79] !== e.smallest)
        begin
            $error("smallest: expected %0d, got %0d", e.smallest, $signed(d[110:79]));
            errors++;
        end
        if (d[142:111] !== e.largest)
        begin
            $error("largest: expected %0d, got %0d", e.largest, $signed(d[142:111]));
            errors++;
        end
        if (d[182:143] !== e.mean_fixed)
        begin
            $error("mean_fixed: expected %0d, got %0d", e.mean_fixed,
                   $signed(d[182:143]));
            errors++;
        end
        if (d[183] !== 1'b0)
        begin
            $error("pad: expected 0, got %0d", d[183]);
            errors++;
        end
    endfunction
endclass

module tb_sorted_table_insert_delete_core;
    localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, no table change
    localparam int         IDLE_LIMIT = 6000;   // cycles without any handshake
    localparam int         HOLD_OFF   = 400;    // long receiver stall

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;    // func[1:0], value[33:2], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [183:0] m_axis_tdata;    // status, element, entry_count, total,
                                   // smallest, largest, mean_fixed, zero pad
    logic         m_axis_tlast;

    table_scoreboard board;
    bit              no_gaps;       // stretches with back-to-back requests
    int              quiet_cycles;

    sorted_table_insert_delete_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // handshake monitors: predictions are made when the request is taken
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tdata[1:0], s_axis_tdata[33:2]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, logic signed [31:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $signed($urandom_range(0, 20)) - 10;     // many duplicates
        else if (r < 8)
            return $urandom;
        else
            return (r == 8) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    // receiver: random stalls, one long hold-off
    initial
    begin
        bit held_off;
        int stall;
        held_off = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && board.results_seen >= 120)
            begin
                held_off = 1;
                stall = HOLD_OFF;
            end
            else
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int                 phase;
        int                 r;
        int                 sent;
        logic signed [31:0] v;

        board         = new();
        no_gaps       = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-table cases, extremes, equal values, absent deletes
        send_request(stid_pkg::FUNC_DUMP, 0);
        send_request(stid_pkg::FUNC_DELETE, 5);
        send_request(FUNC_SPARE, 32'sh7fff_ffff);
        send_request(stid_pkg::FUNC_INSERT, 32'sh7fff_ffff);
        send_request(stid_pkg::FUNC_INSERT, 32'sh8000_0000);
        send_request(stid_pkg::FUNC_INSERT, 0);
        send_request(stid_pkg::FUNC_INSERT, -1);
        send_request(stid_pkg::FUNC_INSERT, 0);
        send_request(stid_pkg::FUNC_INSERT, 32'sh7fff_ffff);
        send_request(stid_pkg::FUNC_DUMP, 32'sh5555_5555);
        send_request(stid_pkg::FUNC_DELETE, 0);
        send_request(stid_pkg::FUNC_DELETE, 12345);
        send_request(stid_pkg::FUNC_DELETE, 32'sh8000_0000);
        send_request(FUNC_SPARE, 0);
        send_request(stid_pkg::FUNC_INSERT, -7);
        send_request(stid_pkg::FUNC_INSERT, 3);
        send_request(stid_pkg::FUNC_DUMP, 32'shffff_ffff);
        send_request(stid_pkg::FUNC_DELETE, 32'sh7fff_ffff);
        send_request(stid_pkg::FUNC_DELETE, 32'sh7fff_ffff);
        send_request(stid_pkg::FUNC_DUMP, 0);
        sent = 20;

        // random: alternate fill, drain and mixed phases so the full table
        // and the empty table are both reached repeatedly
        while (sent < 420)
        begin
            phase   = $urandom_range(0, 2);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(15, 45))
            begin
                r = $urandom_range(0, 99);
                v = pick_value();
                if (sent == 210)
                begin
                    // sender pause until the block has drained
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                    while (board.owed.size() != 0)
                        @(posedge clk);
                end
                if (phase == 0)
                    send_request(r < 88 ? stid_pkg::FUNC_INSERT :
                                 r < 94 ? stid_pkg::FUNC_DELETE :
                                 r < 97 ? stid_pkg::FUNC_DUMP : FUNC_SPARE, v);
                else if (phase == 1 && r < 70 && board.held.size() > 0)
                    send_request(stid_pkg::FUNC_DELETE,
                                 32'(board.held[$urandom_range(0, board.held.size()-1)]));
                else
                    send_request(r < 40 ? stid_pkg::FUNC_INSERT :
                                 r < 80 ? stid_pkg::FUNC_DELETE :
                                 r < 92 ? stid_pkg::FUNC_DUMP : FUNC_SPARE, v);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (board.errors == 0 && board.owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
